// File: src/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, controller codes and command/status types for the
// coil sensitivity combiner.
// ----------------------------------------------------------------------------
package csc_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS + 1;
	localparam int DOT_BITS    = 2 * SAMPLE_BITS + 7;
	localparam int POW_BITS    = 2 * SAMPLE_BITS + 6;
	localparam int QUO_BITS    = 32;
	localparam int CNT_BITS    = $clog2(QUO_BITS);

	localparam logic [1:0] S_ACC  = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_s1;
	} ctrl_status_t;
endpackage

// File: src/csc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_sample_if / csc_result_if
// Valid/ready channels for coil samples and combined voxel results.
// ----------------------------------------------------------------------------
interface csc_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [csc_pkg::SAMPLE_BITS-1:0] image_real;
	logic signed [csc_pkg::SAMPLE_BITS-1:0] image_imag;
	logic signed [csc_pkg::SAMPLE_BITS-1:0] sens_real;
	logic signed [csc_pkg::SAMPLE_BITS-1:0] sens_imag;
	logic                                  last_coil;
	modport source (output valid, image_real, image_imag, sens_real, sens_imag, last_coil,
		input ready);
	modport sink (input valid, image_real, image_imag, sens_real, sens_imag, last_coil,
		output ready);
endinterface

interface csc_result_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] combined_real;
	logic signed [31:0] combined_imag;
	logic              zero_power;
	logic              saturated;
	modport source (output valid, combined_real, combined_imag, zero_power, saturated,
		input ready);
	modport sink (input valid, combined_real, combined_imag, zero_power, saturated,
		output ready);
endinterface

// File: src/csc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ctrl
// Controller: accumulate, load divider, iterate quotient bits, hold result.
// ----------------------------------------------------------------------------
module csc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_last,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  csc_pkg::ctrl_status_t   status,
	output csc_pkg::ctrl_cmd_t      cmd
);
	logic [1:0]                   state_q;
	logic [csc_pkg::CNT_BITS-1:0] cnt_q;

	assign in_ready   = (state_q == csc_pkg::S_ACC);
	assign out_valid  = (state_q == csc_pkg::S_OUT);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.load   = (state_q == csc_pkg::S_LOAD) && status.last_s1;
	assign cmd.step   = (state_q == csc_pkg::S_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csc_pkg::S_ACC;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				csc_pkg::S_ACC: begin
					if (cmd.accept && in_last) state_q <= csc_pkg::S_LOAD;
				end
				csc_pkg::S_LOAD: begin
					cnt_q   <= '0;
					state_q <= csc_pkg::S_DIV;
				end
				csc_pkg::S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == csc_pkg::CNT_BITS'(csc_pkg::QUO_BITS - 1))
						state_q <= csc_pkg::S_OUT;
				end
				csc_pkg::S_OUT: begin
					if (out_ready) state_q <= csc_pkg::S_ACC;
				end
				default: state_q <= csc_pkg::S_ACC;
			endcase
		end
	end
endmodule

// File: src/csc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_datapath
// Product stage, accumulators and two bit-serial restoring dividers.
// ----------------------------------------------------------------------------
module csc_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  csc_pkg::ctrl_cmd_t                     cmd,
	output csc_pkg::ctrl_status_t                  status,
	input  logic signed [csc_pkg::SAMPLE_BITS-1:0] image_real,
	input  logic signed [csc_pkg::SAMPLE_BITS-1:0] image_imag,
	input  logic signed [csc_pkg::SAMPLE_BITS-1:0] sens_real,
	input  logic signed [csc_pkg::SAMPLE_BITS-1:0] sens_imag,
	input  logic                                   last_coil,
	output logic signed [31:0]                     combined_real,
	output logic signed [31:0]                     combined_imag,
	output logic                                   zero_power,
	output logic                                   saturated
);
	localparam int PB = csc_pkg::PROD_BITS;
	localparam int DB = csc_pkg::DOT_BITS;
	localparam int WB = csc_pkg::POW_BITS;
	localparam int QB = csc_pkg::QUO_BITS;

	logic signed [PB-1:0] dr_s1, di_s1, pw_s1;
	logic                 valid_s1, last_s1;
	logic signed [DB-1:0] acc_re_q, acc_im_q, sum_re, sum_im;
	logic [WB-1:0]        acc_pw_q, sum_pw;
	logic [WB-1:0]        div_q;
	logic [WB-1:0]        rem_re_q, rem_im_q;
	logic [QB-1:0]        quo_re_q, quo_im_q;
	logic                 nb_re_q, nb_im_q, neg_re_q, neg_im_q, ovf_re_q, ovf_im_q;
	logic                 zero_q;
	logic [DB-1:0]        mag_re, mag_im;
	logic [WB:0]          t_re, t_im;
	logic [QB-1:0]        lim_re, lim_im, val_re, val_im;
	logic                 sat_re, sat_im;

	assign status.last_s1 = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			last_s1  <= cmd.accept && last_coil;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dr_s1 <= PB'(sens_real * image_real) + PB'(sens_imag * image_imag);
			di_s1 <= PB'(sens_real * image_imag) - PB'(sens_imag * image_real);
			pw_s1 <= PB'(sens_real * sens_real) + PB'(sens_imag * sens_imag);
		end
	end

	assign sum_re = acc_re_q + DB'(dr_s1);
	assign sum_im = acc_im_q + DB'(di_s1);
	assign sum_pw = acc_pw_q + WB'(pw_s1);
	assign mag_re = sum_re[DB-1] ? DB'(-sum_re) : DB'(sum_re);
	assign mag_im = sum_im[DB-1] ? DB'(-sum_im) : DB'(sum_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			acc_pw_q <= '0;
		end else if (cmd.load) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			acc_pw_q <= '0;
		end else if (valid_s1) begin
			acc_re_q <= sum_re;
			acc_im_q <= sum_im;
			acc_pw_q <= sum_pw;
		end
	end

	assign t_re = {rem_re_q, nb_re_q};
	assign t_im = {rem_im_q, nb_im_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q    <= sum_pw;
			zero_q   <= (sum_pw == '0);
			neg_re_q <= sum_re[DB-1];
			neg_im_q <= sum_im[DB-1];
			ovf_re_q <= {1'b0, mag_re} >= {sum_pw, 1'b0};
			ovf_im_q <= {1'b0, mag_im} >= {sum_pw, 1'b0};
			rem_re_q <= WB'(mag_re >> 1);
			rem_im_q <= WB'(mag_im >> 1);
			nb_re_q  <= mag_re[0];
			nb_im_q  <= mag_im[0];
			quo_re_q <= '0;
			quo_im_q <= '0;
		end else if (cmd.step) begin
			nb_re_q <= 1'b0;
			nb_im_q <= 1'b0;
			if (t_re >= {1'b0, div_q}) begin
				rem_re_q <= WB'(t_re - {1'b0, div_q});
				quo_re_q <= {quo_re_q[QB-2:0], 1'b1};
			end else begin
				rem_re_q <= t_re[WB-1:0];
				quo_re_q <= {quo_re_q[QB-2:0], 1'b0};
			end
			if (t_im >= {1'b0, div_q}) begin
				rem_im_q <= WB'(t_im - {1'b0, div_q});
				quo_im_q <= {quo_im_q[QB-2:0], 1'b1};
			end else begin
				rem_im_q <= t_im[WB-1:0];
				quo_im_q <= {quo_im_q[QB-2:0], 1'b0};
			end
		end
	end

	assign lim_re = neg_re_q ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
	assign lim_im = neg_im_q ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
	assign sat_re = ovf_re_q || (quo_re_q > lim_re);
	assign sat_im = ovf_im_q || (quo_im_q > lim_im);
	assign val_re = sat_re ? lim_re : quo_re_q;
	assign val_im = sat_im ? lim_im : quo_im_q;

	assign zero_power    = zero_q;
	assign saturated     = !zero_q && (sat_re || sat_im);
	assign combined_real = zero_q ? '0 : (neg_re_q ? -val_re : val_re);
	assign combined_imag = zero_q ? '0 : (neg_im_q ? -val_im : val_im);
endmodule

// File: src/coil_sensitivity_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coil_sensitivity_combine
// Phase-preserving multi-coil combination: sum(conj(s)*m) / sum(|s|^2).
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one coil's image sample and sensitivity per item; mark
//   the final coil of a voxel with last_coil. Non-last items are taken one
//   per cycle. result carries one combined value per voxel in signed Q0.31.
//   After the last coil is taken, samples.ready stays low while the last
//   product is folded in, the divider is loaded and the bit-serial divider
//   runs (one quotient bit per cycle for both parts); result.valid then
//   rises. samples.ready returns once the result is taken, and while
//   result.ready is low the result holds and no sample is taken.
//   Reset clears the accumulators and the controller; the first voxel may
//   start on the cycle after reset is released.
// ----------------------------------------------------------------------------
module coil_sensitivity_combine (
	input  logic       clk,
	input  logic       arst_n,
	csc_sample_if.sink samples,
	csc_result_if.source result
);
	csc_pkg::ctrl_cmd_t    cmd;
	csc_pkg::ctrl_status_t status;

	csc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last_coil),
		.in_ready  (samples.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	csc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.image_real    (samples.image_real),
		.image_imag    (samples.image_imag),
		.sens_real     (samples.sens_real),
		.sens_imag     (samples.sens_imag),
		.last_coil     (samples.last_coil),
		.combined_real (result.combined_real),
		.combined_imag (result.combined_imag),
		.zero_power    (result.zero_power),
		.saturated     (result.saturated)
	);

	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !samples.ready) else $error("sample taken while result pending");

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.last_coil) |=> !samples.ready)
		else $error("ready after last coil");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.zero_power) |->
		(result.combined_real == 0 && result.combined_imag == 0 && !result.saturated))
		else $error("zero power result not clean");

	a_result_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.step)) else $error("result without division");
endmodule
